/* rtl/toeq_pkg.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue: shared types and constants
// Table sizing, field widths, command and status codes used by every module.
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KIND_W   = 2;
  localparam int TIME_W   = 32;
  localparam int TARGET_W = 16;
  localparam int TYPE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;

  localparam int CMDQ_DEPTH = 2;
  localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
  localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

  // Request kinds as they arrive on the input channel.
  localparam logic [KIND_W-1:0] KIND_FRONT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BACK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SORTED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LIST   = 2'd3;

  typedef enum logic [1:0] {
    OP_FRONT  = 2'd0,
    OP_BACK   = 2'd1,
    OP_SORTED = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_LISTED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic                is_insert;
    logic [TIME_W-1:0]   ev_time;
    logic [TARGET_W-1:0] ev_target;
    logic [TYPE_W-1:0]   ev_type;
  } cmd_t;

  function automatic op_t kind_to_op(input logic [KIND_W-1:0] k);
    op_t op;
    case (k)
      KIND_FRONT:  op = OP_FRONT;
      KIND_BACK:   op = OP_BACK;
      KIND_SORTED: op = OP_SORTED;
      KIND_LIST:   op = OP_LIST;
      default:     op = OP_LIST;
    endcase
    return op;
  endfunction

endpackage

/* rtl/toeq_front.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue: request front end
// Registers each incoming transaction and classifies it into a command.
// ----------------------------------------------------------------------------
module toeq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [toeq_pkg::KIND_W-1:0]   kind,
  input  logic [toeq_pkg::TIME_W-1:0]   event_time,
  input  logic [toeq_pkg::TARGET_W-1:0] event_target,
  input  logic [toeq_pkg::TYPE_W-1:0]   event_type,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output toeq_pkg::cmd_t                cmd
);
  import toeq_pkg::*;

  logic hold_valid;
  cmd_t hold_cmd;
  logic load;

  assign in_stall  = hold_valid && !cmd_ready;
  assign load      = in_valid && !in_stall;
  assign cmd_valid = hold_valid;
  assign cmd       = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_cmd.op        <= kind_to_op(kind);
      hold_cmd.is_insert <= (kind != KIND_LIST);
      hold_cmd.ev_time   <= event_time;
      hold_cmd.ev_target <= event_target;
      hold_cmd.ev_type   <= event_type;
    end
  end

endmodule

/* rtl/toeq_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue: command queue
// Short first-in first-out queue that decouples the front end from the table.
// ----------------------------------------------------------------------------
module toeq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  toeq_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output toeq_pkg::cmd_t pop_cmd
);
  import toeq_pkg::*;

  cmd_t              mem [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(CMDQ_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(CMDQ_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/toeq_back.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue: table and result engine
// Holds the event table as a row of shifting cells, carries out inserts and
// streams list results through the output register.
// ----------------------------------------------------------------------------
module toeq_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  toeq_pkg::cmd_t                  cmd,
  output logic                            cmd_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [toeq_pkg::STATUS_W-1:0]   status,
  output logic [toeq_pkg::TIME_W-1:0]     out_time,
  output logic [toeq_pkg::TARGET_W-1:0]   out_target,
  output logic [toeq_pkg::TYPE_W-1:0]     out_type,
  output logic [toeq_pkg::POS_W-1:0]      out_position,
  output logic                            last
);
  import toeq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  logic [TIME_W-1:0]   slot_time   [TABLE_DEPTH];
  logic [TARGET_W-1:0] slot_target [TABLE_DEPTH];
  logic [TYPE_W-1:0]   slot_type   [TABLE_DEPTH];
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    list_idx;
  logic [IDX_W-1:0]    list_idx_next;
  state_t              state;
  state_t              state_next;

  logic                can_emit;
  logic                take;
  logic                is_full;
  logic                do_insert;
  logic [IDX_W-1:0]    ins_pos;
  logic [IDX_W-1:0]    sort_pos;
  logic [TABLE_DEPTH-1:0] not_less;

  logic                emit;
  status_t             e_status;
  logic [TIME_W-1:0]   e_time;
  logic [TARGET_W-1:0] e_target;
  logic [TYPE_W-1:0]   e_type;
  logic [POS_W-1:0]    e_pos;
  logic                e_last;

  assign can_emit  = !out_valid || !out_stall;
  assign take      = (state == S_IDLE) && cmd_valid && can_emit;
  assign cmd_pop   = take;
  assign is_full   = (count == CNT_W'(TABLE_DEPTH));
  assign do_insert = take && cmd.is_insert && !is_full;

  // Stored entries after the head whose time is not below the new one.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      not_less[i] = (i != 0) && (CNT_W'(i) < count) && (slot_time[i] >= cmd.ev_time);
    end
  end

  // First qualifying entry wins; with none the event goes to the back.
  always_comb begin
    sort_pos = IDX_W'(count);
    for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
      if (not_less[i]) begin
        sort_pos = IDX_W'(i);
      end
    end
  end

  always_comb begin
    case (cmd.op)
      OP_FRONT:  ins_pos = '0;
      OP_BACK:   ins_pos = IDX_W'(count);
      OP_SORTED: begin
        if (count == '0 || cmd.ev_time < slot_time[0]) begin
          ins_pos = '0;
        end else begin
          ins_pos = sort_pos;
        end
      end
      default:   ins_pos = '0;
    endcase
  end

  always_comb begin
    emit          = 1'b0;
    e_status      = ST_INSERTED;
    e_time        = '0;
    e_target      = '0;
    e_type        = '0;
    e_pos         = '0;
    e_last        = 1'b1;
    state_next    = state;
    list_idx_next = list_idx;
    case (state)
      S_LIST: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_status = ST_LISTED;
          e_time   = slot_time[list_idx];
          e_target = slot_target[list_idx];
          e_type   = slot_type[list_idx];
          e_pos    = POS_W'(list_idx);
          e_last   = (CNT_W'(list_idx) + 1'b1 == count);
          if (e_last) begin
            state_next = S_IDLE;
          end else begin
            list_idx_next = list_idx + 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (take) begin
          emit = 1'b1;
          if (cmd.op == OP_LIST) begin
            if (count == '0) begin
              e_status = ST_EMPTY;
            end else begin
              e_status = ST_LISTED;
              e_time   = slot_time[0];
              e_target = slot_target[0];
              e_type   = slot_type[0];
              e_last   = (count == CNT_W'(1));
              if (!e_last) begin
                state_next    = S_LIST;
                list_idx_next = IDX_W'(1);
              end
            end
          end else if (is_full) begin
            e_status = ST_FULL;
          end else begin
            e_status = ST_INSERTED;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      list_idx  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      list_idx <= list_idx_next;
      if (do_insert) begin
        count <= count + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Entries from the insert position up to the fill level move one place on.
  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (IDX_W'(i) == ins_pos) begin
          slot_time[i]   <= cmd.ev_time;
          slot_target[i] <= cmd.ev_target;
          slot_type[i]   <= cmd.ev_type;
        end else if (i != 0 && IDX_W'(i) > ins_pos && CNT_W'(i) <= count) begin
          slot_time[i]   <= slot_time[(i == 0) ? 0 : i - 1];
          slot_target[i] <= slot_target[(i == 0) ? 0 : i - 1];
          slot_type[i]   <= slot_type[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status       <= e_status;
      out_time     <= e_time;
      out_target   <= e_target;
      out_type     <= e_type;
      out_position <= e_pos;
      last         <= e_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_list_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |-> (list_idx != '0 && CNT_W'(list_idx) < count))
    else $error("list index outside the stored entries");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> (count == CNT_W'($past(count) + 1'b1)))
    else $error("entry count moved by other than one insert");

  a_list_frozen: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && state == S_LIST) |-> (count == $past(count)))
    else $error("table changed while a list was streaming");
`endif

endmodule

/* rtl/time_ordered_event_queue_top.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue
// Bounded event table with front, back and time-ordered insertion and a
// streaming list request.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid / in_stall  kind, event_time, event_target, event_type
//  output   out_valid/ out_stall status, out_time, out_target, out_type,
//                                out_position, last
//
// An insert is carried out by the table engine and gives one transaction; a
// list request gives one transaction per stored entry, or one empty status,
// one a cycle while the output is not stalled, and occupies the engine till done.
// A request reaches its result through the front register, the two-entry
// command queue and the output register.
// Synchronous reset empties the table; entries are not cleared.
// A stall on the output holds the engine; the queue and the front register
// absorb three commands before the input stalls.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [toeq_pkg::KIND_W-1:0]   kind,
  input  logic [toeq_pkg::TIME_W-1:0]   event_time,
  input  logic [toeq_pkg::TARGET_W-1:0] event_target,
  input  logic [toeq_pkg::TYPE_W-1:0]   event_type,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [toeq_pkg::STATUS_W-1:0] status,
  output logic [toeq_pkg::TIME_W-1:0]   out_time,
  output logic [toeq_pkg::TARGET_W-1:0] out_target,
  output logic [toeq_pkg::TYPE_W-1:0]   out_type,
  output logic [toeq_pkg::POS_W-1:0]    out_position,
  output logic                          last
);
  import toeq_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic queue_ready;
  cmd_t queue_cmd;
  logic queue_valid;
  logic queue_pop;

  toeq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .event_time   (event_time),
    .event_target (event_target),
    .event_type   (event_type),
    .cmd_valid    (front_valid),
    .cmd_ready    (queue_ready),
    .cmd          (front_cmd)
  );

  toeq_cmd_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (queue_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop        (queue_pop),
    .pop_cmd    (queue_cmd)
  );

  toeq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (queue_valid),
    .cmd          (queue_cmd),
    .cmd_pop      (queue_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_time     (out_time),
    .out_target   (out_target),
    .out_type     (out_type),
    .out_position (out_position),
    .last         (last)
  );

endmodule

/* verif/time_ordered_event_queue_top_tb.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue testbench
// Drives front, back and time-ordered inserts and list requests through the
// valid/stall channels. A scoreboard keeps its own copy of the event table,
// works out the transactions each request must give and checks every result
// field by field. Sender gaps and receiver stalls vary from phase to phase,
// and one long receiver hold makes the block back up and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_ordered_event_queue_top_tb;
  import toeq_pkg::*;

  localparam int          RANDOM_ITEMS_PER_PHASE = 118;
  localparam int          HOLD_CYCLES            = 200;
  localparam int          DRAIN_CYCLES           = 10;
  localparam longint      TIMEOUT_NS             = 5_000_000;

  typedef struct packed {
    status_t             result_status;
    logic [TIME_W-1:0]   result_time;
    logic [TARGET_W-1:0] result_target;
    logic [TYPE_W-1:0]   result_type;
    logic [POS_W-1:0]    result_position;
    logic                result_last;
  } event_result_t;

  class event_table_scoreboard;
    logic [TIME_W-1:0]   slot_time   [TABLE_DEPTH];
    logic [TARGET_W-1:0] slot_target [TABLE_DEPTH];
    logic [TYPE_W-1:0]   slot_type   [TABLE_DEPTH];
    int unsigned         entry_count = 0;
    event_result_t       expected_results [$];
    int unsigned         error_count = 0;

    // Updates the table copy for one accepted request and queues the
    // transactions it must produce.
    function void note_request(logic [KIND_W-1:0] k, logic [TIME_W-1:0] t,
                               logic [TARGET_W-1:0] tg, logic [TYPE_W-1:0] ty);
      event_result_t res;
      int unsigned   pos;
      int unsigned   i;
      res = '0;
      res.result_last = 1'b1;
      if (k == KIND_LIST) begin
        if (entry_count == 0) begin
          res.result_status = ST_EMPTY;
          expected_results.push_back(res);
        end else begin
          for (i = 0; i < entry_count; i++) begin
            res.result_status   = ST_LISTED;
            res.result_time     = slot_time[i];
            res.result_target   = slot_target[i];
            res.result_type     = slot_type[i];
            res.result_position = i[POS_W-1:0];
            res.result_last     = (i + 1 == entry_count);
            expected_results.push_back(res);
          end
        end
      end else if (entry_count >= TABLE_DEPTH) begin
        res.result_status = ST_FULL;
        expected_results.push_back(res);
      end else begin
        if (k == KIND_FRONT) begin
          pos = 0;
        end else if (k == KIND_BACK) begin
          pos = entry_count;
        end else if (entry_count == 0 || t < slot_time[0]) begin
          pos = 0;
        end else begin
          // A tie with the head never displaces it; later ties are displaced.
          pos = 1;
          while (pos < entry_count && slot_time[pos] < t) pos++;
        end
        for (i = entry_count; i > pos; i--) begin
          slot_time[i]   = slot_time[i-1];
          slot_target[i] = slot_target[i-1];
          slot_type[i]   = slot_type[i-1];
        end
        slot_time[pos]   = t;
        slot_target[pos] = tg;
        slot_type[pos]   = ty;
        entry_count++;
        res.result_status = ST_INSERTED;
        expected_results.push_back(res);
      end
    endfunction

    function void report_mismatch(string field, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(event_result_t got);
      event_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction, status", '0,
                        TIME_W'(got.result_status));
        return;
      end
      want = expected_results.pop_front();
      if (got.result_status !== want.result_status)
        report_mismatch("status", TIME_W'(want.result_status),
                        TIME_W'(got.result_status));
      if (got.result_time !== want.result_time)
        report_mismatch("out_time", want.result_time, got.result_time);
      if (got.result_target !== want.result_target)
        report_mismatch("out_target", TIME_W'(want.result_target),
                        TIME_W'(got.result_target));
      if (got.result_type !== want.result_type)
        report_mismatch("out_type", TIME_W'(want.result_type),
                        TIME_W'(got.result_type));
      if (got.result_position !== want.result_position)
        report_mismatch("out_position", TIME_W'(want.result_position),
                        TIME_W'(got.result_position));
      if (got.result_last !== want.result_last)
        report_mismatch("last", TIME_W'(want.result_last), TIME_W'(got.result_last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   kind;
  logic [TIME_W-1:0]   event_time;
  logic [TARGET_W-1:0] event_target;
  logic [TYPE_W-1:0]   event_type;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [TIME_W-1:0]   out_time;
  logic [TARGET_W-1:0] out_target;
  logic [TYPE_W-1:0]   out_type;
  logic [POS_W-1:0]    out_position;
  logic                last;

  event_table_scoreboard table_sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_pending = 1'b0;

  time_ordered_event_queue_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .event_time   (event_time),
    .event_target (event_target),
    .event_type   (event_type),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_time     (out_time),
    .out_target   (out_target),
    .out_type     (out_type),
    .out_position (out_position),
    .last         (last)
  );

  always #5 clk = ~clk;

  // Offers one request and returns at the edge where it is taken. Handshake
  // signals are sampled on the falling edge, when everything has settled.
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                              input logic [TARGET_W-1:0] tg, input logic [TYPE_W-1:0] ty);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    event_time   <= t;
    event_target <= tg;
    event_type   <= ty;
    do @(negedge clk); while (in_stall);
    table_sb.note_request(k, t, tg, ty);
    @(posedge clk);
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [KIND_W-1:0] k;
    logic [TIME_W-1:0] t;
    int unsigned       sel;
    int                n;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    for (n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
      k   = KIND_W'($urandom_range(3));
      sel = $urandom_range(3);
      // Reuse stored times often so that ties are common in sorted inserts.
      if (sel == 0 && table_sb.entry_count != 0)
        t = table_sb.slot_time[$urandom_range(table_sb.entry_count - 1)];
      else if (sel == 1)
        t = $urandom_range(15);
      else
        t = $urandom;
      send_request(k, t, TARGET_W'($urandom), TYPE_W'($urandom));
    end
  endtask

  // Result side: stall decisions at the rising edge, checks on the falling
  // edge ahead of the edge that takes the transaction.
  initial begin : result_sink
    int unsigned held;
    held      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall)
        table_sb.check_result({status_t'(status), out_time, out_target, out_type,
                               out_position, last});
      @(posedge clk);
      if (hold_pending) begin
        out_stall <= 1'b1;
        held++;
        if (held == HOLD_CYCLES) begin
          hold_pending = 1'b0;
          held         = 0;
        end
      end else begin
        out_stall <= (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
      end
    end
  end

  initial begin : stimulus
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_FRONT;
    event_time   = '0;
    event_target = '0;
    event_type   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty list, each insert kind, ties with the head and
    // with later entries, and the extremes of every field.
    send_request(KIND_LIST,   32'h0000_0000, 16'h0000, 16'h0000);
    send_request(KIND_SORTED, 32'h0001_0000, 16'h0001, 16'h0010);
    send_request(KIND_SORTED, 32'h0001_0000, 16'h0002, 16'h0020);
    send_request(KIND_SORTED, 32'h0000_8000, 16'h0003, 16'h0030);
    send_request(KIND_FRONT,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_request(KIND_BACK,   32'h0000_0000, 16'h0000, 16'h0000);
    send_request(KIND_SORTED, 32'h0001_0000, 16'h0004, 16'h0040);
    send_request(KIND_LIST,   32'h1234_5678, 16'hA5A5, 16'h5A5A);
    send_request(KIND_SORTED, 32'hFFFF_FFFF, 16'h0005, 16'h0050);
    send_request(KIND_SORTED, 32'h0000_0000, 16'h0006, 16'h0060);
    send_request(KIND_LIST,   32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);

    // The random part fills the table, after which every insert kind is
    // rejected as full and every list streams all sixteen entries.
    hold_pending = 1'b1;
    run_random_phase(0, 0);
    run_random_phase(88, 0);
    run_random_phase(0, 88);
    run_random_phase(32, 32);
    in_valid <= 1'b0;

    while (table_sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_sb.error_count == 0 && table_sb.expected_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/toeq_pkg.sv
rtl/toeq_front.sv
rtl/toeq_cmd_fifo.sv
rtl/toeq_back.sv
rtl/time_ordered_event_queue_top.sv
verif/time_ordered_event_queue_top_tb.sv
